@@ rtl/rrip_pkg.sv @@
package rrip_pkg;

    localparam int SET_COUNT   = 64;
    localparam int WAYS        = 2;
    localparam int BLOCK_BYTES = 64;

    localparam int ADDR_W   = 64;
    localparam int OFFSET_W = $clog2(BLOCK_BYTES);
    localparam int SET_W    = $clog2(SET_COUNT);
    localparam int SET_AW   = (SET_W > 0) ? SET_W : 1;
    localparam int WAY_AW   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int TAG_W    = ADDR_W - OFFSET_W - SET_W;
    localparam int RRPV_W   = 2;
    localparam int CONF_W   = 2;

    // output tdata layout, lowest bit up
    localparam int OUT_BITS  = 1 + 6 + 1 + 1 + 1 + 2 + 1 + ADDR_W;
    localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [RRPV_W-1:0] RRPV_TOP  = 2'd3;
    localparam logic [RRPV_W-1:0] RRPV_FILL = 2'd2;
    localparam logic [RRPV_W-1:0] RRPV_USED = 2'd0;
    localparam logic [CONF_W-1:0] CONF_MAX  = 2'd2;

    typedef enum logic [1:0] {
        PF_NONE    = 2'd0,
        PF_PRESENT = 2'd1,
        PF_SKIP    = 2'd2,
        PF_FILL    = 2'd3
    } pf_outcome_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_PF
    } state_t;

    // one set of the line store
    typedef struct packed {
        logic [WAYS-1:0][TAG_W-1:0]  tag;
        logic [WAYS-1:0][RRPV_W-1:0] rrpv;
        logic [WAYS-1:0]             pf;
    } row_t;

    localparam int ROW_W = $bits(row_t);

endpackage

@@ rtl/rrip_cache_with_stride_prefetch.sv @@
// Set-associative tag store (SET_COUNT x WAYS lines) with 2-bit SRRIP replacement
// and one global stride prefetcher. Each request on s_axis carries a demand byte
// address and yields exactly one result on m_axis with the demand hit/fill
// information and the outcome of the prefetch it triggered. An item passes through
// accept with the set reads launched, lookup with the demand write-back, then the
// prefetch write-back (on a fill) together with loading the result register. The
// line memory has a single write port, so the two write-backs use separate states;
// a new request is taken in the cycle after the result is loaded. Valid bits live
// in flip-flops and clear at reset, so no clearing pass over the memory is needed.
module rrip_cache_with_stride_prefetch
    import rrip_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [63:0]      s_axis_tdata,   // [63:0] address
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // [0] hit, [6:1] demand_set, [7] demand_way, [8] hit_on_prefetched,
    // [9] demand_evicted_unused_prefetch, [11:10] prefetch_outcome,
    // [12] prefetch_evicted_unused_prefetch, [76:13] prefetch_address, rest zero
    output logic [OUT_W-1:0] m_axis_tdata
);

    function automatic logic [WAY_AW-1:0] lowest(input logic [WAYS-1:0] m);
        logic [WAY_AW-1:0] r;
        r = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (m[w])
            begin
                r = WAY_AW'(w);
            end
        end
        return r;
    endfunction

    state_t state_reg, state_next;

    // predictor
    logic [ADDR_W-1:0] last_address_reg;
    logic [ADDR_W-1:0] last_stride_reg;
    logic [CONF_W-1:0] conf_reg;
    logic              started_reg;

    // per-item registers
    logic [SET_AW-1:0] dset_reg;
    logic [TAG_W-1:0]  dtag_reg;
    logic [ADDR_W-1:0] pf_addr_reg;
    logic [SET_AW-1:0] pset_reg;
    logic [TAG_W-1:0]  ptag_reg;
    logic              attempt_reg;

    logic [SET_COUNT-1:0][WAYS-1:0] valid_reg;
    logic [ROW_W-1:0]  line_mem [SET_COUNT];
    row_t              rd_dem_reg, rd_pf_reg;

    // results held from lookup to write-back
    logic              hit_reg;
    logic [WAY_AW-1:0] dway_reg;
    logic              hit_pf_reg;
    logic              dem_evict_reg;
    pf_outcome_t       outcome_reg;
    logic              pf_evict_reg;
    row_t              pf_row_reg;
    logic [WAY_AW-1:0] pf_way_reg;
    logic              pf_fill_reg;

    logic              m_valid_reg;
    logic [OUT_W-1:0]  m_data_reg;

    logic accept, look, pf_go;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign look          = (state_reg == ST_LOOK);
    assign pf_go         = (state_reg == ST_PF) && (!m_valid_reg || m_axis_tready);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // ---------------- accept stage ----------------
    logic [ADDR_W-1:0] in_addr, in_blk, diff, pf_addr_next, pf_blk;
    logic              same_stride, attempt_next;
    logic [SET_AW-1:0] in_set, in_pset;

    always_comb
    begin
        in_addr      = s_axis_tdata;
        in_blk       = in_addr >> OFFSET_W;
        in_set       = SET_AW'(in_blk % SET_COUNT);
        diff         = in_addr - last_address_reg;
        same_stride  = (diff == last_stride_reg);
        // with a repeated stride the stride register does not change
        pf_addr_next = in_addr + last_stride_reg;
        pf_blk       = pf_addr_next >> OFFSET_W;
        in_pset      = SET_AW'(pf_blk % SET_COUNT);
        attempt_next = started_reg && same_stride && (conf_reg != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_address_reg <= '0;
            last_stride_reg  <= '0;
            conf_reg         <= '0;
            started_reg      <= 1'b0;
        end
        else if (accept)
        begin
            last_address_reg <= in_addr;
            if (!started_reg)
            begin
                conf_reg    <= '0;
                started_reg <= 1'b1;
            end
            else if (same_stride)
            begin
                if (conf_reg < CONF_MAX)
                begin
                    conf_reg <= conf_reg + 2'd1;
                end
            end
            else
            begin
                conf_reg        <= '0;
                last_stride_reg <= diff;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dset_reg    <= in_set;
            dtag_reg    <= TAG_W'(in_blk >> SET_W);
            pf_addr_reg <= pf_addr_next;
            pset_reg    <= in_pset;
            ptag_reg    <= TAG_W'(pf_blk >> SET_W);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attempt_reg <= 1'b0;
        end
        else if (accept)
        begin
            attempt_reg <= attempt_next;
        end
    end

    // ---------------- lookup stage ----------------
    logic [WAYS-1:0]             dem_v, dem_hit_m, dem_free_m, dem_cold_m, new_v;
    logic [WAYS-1:0][RRPV_W-1:0] dem_rr, dem_aged;
    logic [RRPV_W-1:0]           dem_top, dem_age;
    row_t                        dem_row, new_row;
    logic                        dem_hit, dem_evict, hit_pf;
    logic [WAY_AW-1:0]           dem_way;

    always_comb
    begin
        dem_v   = valid_reg[dset_reg];
        dem_row = rd_dem_reg;
        dem_top = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            dem_hit_m[w]  = dem_v[w] && (dem_row.tag[w] == dtag_reg);
            dem_free_m[w] = !dem_v[w];
            dem_rr[w]     = dem_v[w] ? dem_row.rrpv[w] : RRPV_TOP;
            if (dem_rr[w] > dem_top)
            begin
                dem_top = dem_rr[w];
            end
        end
        // zero when some line already sits at the top
        dem_age = RRPV_TOP - dem_top;
        for (int w = 0; w < WAYS; w++)
        begin
            dem_aged[w]   = dem_rr[w] + dem_age;
            dem_cold_m[w] = (dem_aged[w] == RRPV_TOP);
        end
        dem_hit   = |dem_hit_m;
        new_row   = dem_row;
        new_v     = dem_v;
        dem_evict = 1'b0;
        hit_pf    = 1'b0;
        if (dem_hit)
        begin
            dem_way              = lowest(dem_hit_m);
            hit_pf               = dem_row.pf[dem_way];
            new_row.rrpv[dem_way] = RRPV_USED;
            new_row.pf[dem_way]   = 1'b0;
        end
        else
        begin
            dem_way = (|dem_free_m) ? lowest(dem_free_m) : lowest(dem_cold_m);
            if (!(|dem_free_m))
            begin
                new_row.rrpv = dem_aged;
            end
            dem_evict             = dem_v[dem_way] && dem_row.pf[dem_way];
            new_row.tag[dem_way]  = dtag_reg;
            new_row.rrpv[dem_way] = RRPV_FILL;
            new_row.pf[dem_way]   = 1'b0;
            new_v[dem_way]        = 1'b1;
        end
    end

    // prefetch sees the demand set as the demand access left it
    logic                        same_set;
    row_t                        base_row, pf_row;
    logic [WAYS-1:0]             base_v, pf_hit_m, pf_free_m, pf_cold_m;
    logic [WAY_AW-1:0]           pf_way;
    pf_outcome_t                 outcome;
    logic                        pf_evict;

    always_comb
    begin
        same_set = (pset_reg == dset_reg);
        base_row = same_set ? new_row : rd_pf_reg;
        base_v   = same_set ? new_v : valid_reg[pset_reg];
        for (int w = 0; w < WAYS; w++)
        begin
            pf_hit_m[w]  = base_v[w] && (base_row.tag[w] == ptag_reg);
            pf_free_m[w] = !base_v[w];
            pf_cold_m[w] = base_v[w] && (base_row.rrpv[w] == RRPV_TOP);
        end
        pf_way   = (|pf_free_m) ? lowest(pf_free_m) : lowest(pf_cold_m);
        pf_row   = base_row;
        pf_evict = 1'b0;
        if (!attempt_reg)
        begin
            outcome = PF_NONE;
        end
        else if (|pf_hit_m)
        begin
            outcome = PF_PRESENT;
        end
        else if (!(|pf_free_m) && !(|pf_cold_m))
        begin
            outcome = PF_SKIP;
        end
        else
        begin
            outcome = PF_FILL;
            pf_evict = base_v[pf_way] && base_row.pf[pf_way];
        end
        pf_row.tag[pf_way]  = ptag_reg;
        pf_row.rrpv[pf_way] = RRPV_TOP;
        pf_row.pf[pf_way]   = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (look)
        begin
            hit_reg       <= dem_hit;
            dway_reg      <= dem_way;
            hit_pf_reg    <= hit_pf;
            dem_evict_reg <= dem_evict;
            outcome_reg   <= outcome;
            pf_evict_reg  <= pf_evict;
            pf_row_reg    <= pf_row;
            pf_way_reg    <= pf_way;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pf_fill_reg <= 1'b0;
        end
        else if (look)
        begin
            pf_fill_reg <= (outcome == PF_FILL);
        end
    end

    // ---------------- line store ----------------
    logic              mem_we;
    logic [SET_AW-1:0] mem_wa;
    logic [ROW_W-1:0]  mem_wd;

    always_comb
    begin
        mem_we = look || (pf_go && pf_fill_reg);
        mem_wa = look ? dset_reg : pset_reg;
        mem_wd = look ? new_row : pf_row_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            line_mem[mem_wa] <= mem_wd;
        end
        if (accept)
        begin
            rd_dem_reg <= line_mem[in_set];
            rd_pf_reg  <= line_mem[in_pset];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (look)
        begin
            valid_reg[dset_reg] <= new_v;
        end
        else if (pf_go && pf_fill_reg)
        begin
            valid_reg[pset_reg][pf_way_reg] <= 1'b1;
        end
    end

    // ---------------- result register ----------------
    logic [63:0]       set_wide, way_wide;
    logic [ADDR_W-1:0] out_pf_addr;
    logic [OUT_W-1:0]  out_word;

    always_comb
    begin
        set_wide    = 64'(dset_reg);
        way_wide    = 64'(dway_reg);
        out_pf_addr = (outcome_reg == PF_NONE) ? '0 : pf_addr_reg;
        out_word    = OUT_W'({out_pf_addr, pf_evict_reg, outcome_reg, dem_evict_reg,
                              hit_pf_reg, way_wide[0], set_wide[5:0], hit_reg});
    end

    always_ff @(posedge clk)
    begin
        if (pf_go)
        begin
            m_data_reg <= out_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (pf_go)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                state_next = ST_PF;
            end
            ST_PF:
            begin
                if (pf_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---------------- assertions ----------------
    a_result_from_pf: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg) == ST_PF)
        else $error("result appeared outside the write-back cycle");

    a_accept_to_look: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> state_reg == ST_LOOK)
        else $error("accepted request did not move to lookup");

    a_demand_line_valid: assert property (@(posedge clk) disable iff (!rst_n)
        look |=> valid_reg[dset_reg][dway_reg])
        else $error("demand line not valid after lookup");

    a_fill_needs_attempt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PF && pf_fill_reg) |-> attempt_reg)
        else $error("prefetch fill without a prefetch attempt");

endmodule
